// File: sv/b64u_pkg.sv
package b64u_pkg;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_CHAR   = 2'd1,
    ST_TRAIL_BITS = 2'd2,
    ST_BAD_LEN    = 2'd3
  } status_t;

  typedef enum logic {
    DIR_DECODE = 1'b0,
    DIR_ENCODE = 1'b1
  } dir_t;

  typedef struct packed {
    logic [7:0] data;
    logic       data_valid;
    logic       last;
    status_t    status;
  } res_t;

  // 6-bit value to alphabet character
  function automatic logic [7:0] enc_char(input logic [5:0] v);
    logic [7:0] c;
    c = 8'h00;
    if (v < 6'd26) begin
      c = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'h61 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      c = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      c = 8'h2d;
    end else begin
      c = 8'h5f;
    end
    return c;
  endfunction

  // character to {ok, 6-bit value}
  function automatic logic [6:0] dec_sym(input logic [7:0] c);
    logic [6:0] r;
    r = 7'd0;
    if (c >= 8'h41 && c <= 8'h5a) begin
      r = {1'b1, 6'(c - 8'h41)};
    end else if (c >= 8'h61 && c <= 8'h7a) begin
      r = {1'b1, 6'(c - 8'h61 + 8'd26)};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 6'(c - 8'h30 + 8'd52)};
    end else if (c == 8'h2d) begin
      r = {1'b1, 6'd62};
    end else if (c == 8'h5f) begin
      r = {1'b1, 6'd63};
    end
    return r;
  endfunction

endpackage

// File: sv/b64u_in_if.sv
interface b64u_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

// File: sv/b64u_out_if.sv
interface b64u_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_valid;
  logic       out_last;
  logic [1:0] status;

  modport source (output valid, output out_byte, output out_valid, output out_last,
                  output status, input ready);
  modport sink (input valid, input out_byte, input out_valid, input out_last,
                input status, output ready);
endinterface

// File: sv/base64url_codec_unpadded.sv
// Unpadded base64url codec (A-Z a-z 0-9 - _). cfg_wdata written with cfg_we picks the
// direction (1 encode, 0 decode) and clears the message state. Each accepted word is
// translated in the cycle it is accepted and its results (none, one or two) are pushed
// into a 4-entry result queue that drives the output channel, so results are registered
// before they appear. Input is taken whenever the queue has room for two results:
// with the output side always ready, one word enters per cycle while each word makes at
// most one result; a word that makes two results (encode) needs the single output port
// for both. Decode errors are sticky; on the last character a decode ends with a last
// result that carries the final byte if there is one and no error, else status only.
module base64url_codec_unpadded (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  b64u_in_if.sink    in_if,
  b64u_out_if.source out_if
);

  b64u_pkg::dir_t    dir_r;
  logic [11:0]       bit_buffer_r, bit_buffer_nxt;
  logic [3:0]        bit_count_r, bit_count_nxt;
  logic [1:0]        char_phase_r, char_phase_nxt;
  b64u_pkg::status_t error_r, error_nxt;

  b64u_pkg::res_t    q_r [b64u_pkg::QDepth];
  logic [b64u_pkg::QPtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [b64u_pkg::QCntW-1:0] q_cnt_r;

  b64u_pkg::res_t    res0, res1;
  logic [1:0]        n_push;
  logic              in_fire, out_fire;

  // encode path
  logic [11:0] ebuf;
  // decode path
  logic [6:0]  sym;
  logic [11:0] dbuf;
  logic [3:0]  dcnt;
  logic [1:0]  dphase;
  logic [7:0]  dbyte;
  logic        dhave;
  logic [11:0] tmask;
  b64u_pkg::status_t derr;

  assign in_if.ready = (q_cnt_r <= b64u_pkg::QCntW'(b64u_pkg::QDepth - 2));
  assign in_fire     = in_if.valid && in_if.ready;
  assign out_fire    = out_if.valid && out_if.ready;

  always_comb begin
    res0           = '0;
    res1           = '0;
    n_push         = 2'd0;
    bit_buffer_nxt = bit_buffer_r;
    bit_count_nxt  = bit_count_r;
    char_phase_nxt = char_phase_r;
    error_nxt      = error_r;

    ebuf  = {bit_buffer_r[3:0], in_if.in_byte};
    sym   = b64u_pkg::dec_sym(in_if.in_byte);
    dbuf  = {bit_buffer_r[5:0], sym[5:0]};
    dcnt  = bit_count_r;
    dphase = char_phase_r;
    dbyte = 8'h00;
    dhave = 1'b0;
    derr  = error_r;
    tmask = 12'h000;

    if (dir_r == b64u_pkg::DIR_ENCODE) begin
      res0.data_valid = 1'b1;
      res1.data_valid = 1'b1;
      bit_buffer_nxt  = ebuf;
      case (bit_count_r)
        4'd2: begin
          res0.data     = b64u_pkg::enc_char(ebuf[9:4]);
          res1.data     = b64u_pkg::enc_char({ebuf[3:0], 2'b00});
          bit_count_nxt = 4'd4;
          n_push        = in_if.in_last ? 2'd2 : 2'd1;
        end
        4'd4: begin
          res0.data     = b64u_pkg::enc_char(ebuf[11:6]);
          res1.data     = b64u_pkg::enc_char(ebuf[5:0]);
          bit_count_nxt = 4'd0;
          n_push        = 2'd2;
        end
        default: begin
          res0.data     = b64u_pkg::enc_char(ebuf[7:2]);
          res1.data     = b64u_pkg::enc_char({ebuf[1:0], 4'b0000});
          bit_count_nxt = 4'd2;
          n_push        = in_if.in_last ? 2'd2 : 2'd1;
        end
      endcase
      if (in_if.in_last) begin
        if (n_push == 2'd2) begin
          res1.last = 1'b1;
        end else begin
          res0.last = 1'b1;
        end
      end
    end else begin
      if (error_r == b64u_pkg::ST_OK) begin
        if (!sym[6]) begin
          derr = b64u_pkg::ST_BAD_CHAR;
        end else begin
          dphase         = char_phase_r + 2'd1;
          bit_buffer_nxt = dbuf;
          case (bit_count_r)
            4'd6: begin
              dcnt  = 4'd4;
              dbyte = dbuf[11:4];
              dhave = 1'b1;
            end
            4'd4: begin
              dcnt  = 4'd2;
              dbyte = dbuf[9:2];
              dhave = 1'b1;
            end
            4'd2: begin
              dcnt  = 4'd0;
              dbyte = dbuf[7:0];
              dhave = 1'b1;
            end
            default: begin
              dcnt = 4'd6;
            end
          endcase
        end
      end
      bit_count_nxt  = dcnt;
      char_phase_nxt = dphase;
      if (!in_if.in_last) begin
        res0.data       = dbyte;
        res0.data_valid = 1'b1;
        n_push          = dhave ? 2'd1 : 2'd0;
      end else begin
        tmask = (12'd1 << dcnt) - 12'd1;
        if (derr == b64u_pkg::ST_OK && dcnt != 4'd0 && dcnt < 4'd12 &&
            (bit_buffer_nxt & tmask) != 12'h000) begin
          derr = b64u_pkg::ST_TRAIL_BITS;
        end
        if (derr == b64u_pkg::ST_OK && dphase == 2'd1) begin
          derr = b64u_pkg::ST_BAD_LEN;
        end
        res0.last = 1'b1;
        n_push    = 2'd1;
        if (derr == b64u_pkg::ST_OK && dhave) begin
          res0.data       = dbyte;
          res0.data_valid = 1'b1;
        end else begin
          res0.status = derr;
        end
      end
      error_nxt = derr;
    end

    // message done: back to a clean state
    if (in_if.in_last) begin
      bit_buffer_nxt = '0;
      bit_count_nxt  = '0;
      char_phase_nxt = '0;
      error_nxt      = b64u_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r        <= b64u_pkg::DIR_DECODE;
      bit_buffer_r <= '0;
      bit_count_r  <= '0;
      char_phase_r <= '0;
      error_r      <= b64u_pkg::ST_OK;
    end else if (cfg_we) begin
      dir_r        <= b64u_pkg::dir_t'(cfg_wdata);
      bit_buffer_r <= '0;
      bit_count_r  <= '0;
      char_phase_r <= '0;
      error_r      <= b64u_pkg::ST_OK;
    end else if (in_fire) begin
      bit_buffer_r <= bit_buffer_nxt;
      bit_count_r  <= bit_count_nxt;
      char_phase_r <= char_phase_nxt;
      error_r      <= error_nxt;
    end
  end

  // result queue
  always_ff @(posedge clk) begin
    if (in_fire && n_push != 2'd0) begin
      q_r[wr_ptr_r] <= res0;
    end
    if (in_fire && n_push == 2'd2) begin
      q_r[wr_ptr_r + b64u_pkg::QPtrW'(1)] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      q_cnt_r  <= '0;
    end else begin
      if (in_fire) begin
        wr_ptr_r <= wr_ptr_r + b64u_pkg::QPtrW'(n_push);
      end
      if (out_fire) begin
        rd_ptr_r <= rd_ptr_r + b64u_pkg::QPtrW'(1);
      end
      q_cnt_r <= q_cnt_r + (in_fire ? b64u_pkg::QCntW'(n_push) : '0)
                         - (out_fire ? b64u_pkg::QCntW'(1) : '0);
    end
  end

  assign out_if.valid     = (q_cnt_r != '0);
  assign out_if.out_byte  = q_r[rd_ptr_r].data;
  assign out_if.out_valid = q_r[rd_ptr_r].data_valid;
  assign out_if.out_last  = q_r[rd_ptr_r].last;
  assign out_if.status    = q_r[rd_ptr_r].status;

endmodule

// File: sv/b64u_chk.sv
module b64u_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       o_vld,
  input logic       o_rdy,
  input logic [7:0] o_byte,
  input logic       o_data_valid,
  input logic       o_last,
  input logic [1:0] o_status
);

  // an error status only rides on a status-only final word
  a_status_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    o_vld && o_status != 2'd0 |-> o_last && !o_data_valid)
    else $error("error status on a word that is not a status-only last");

  // a status-only word always closes the message
  a_nodata_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    o_vld && !o_data_valid |-> o_last)
    else $error("status-only word without last");

  a_nodata_zero: assert property (@(posedge clk) disable iff (!rst_n)
    o_vld && !o_data_valid |-> o_byte == 8'h00)
    else $error("status-only word carries a nonzero byte");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    o_vld && !o_rdy |=> o_vld && $stable(o_byte) && $stable(o_data_valid) &&
                        $stable(o_last) && $stable(o_status))
    else $error("output word changed while stalled");

endmodule

bind base64url_codec_unpadded b64u_chk u_b64u_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .o_vld        (out_if.valid),
  .o_rdy        (out_if.ready),
  .o_byte       (out_if.out_byte),
  .o_data_valid (out_if.out_valid),
  .o_last       (out_if.out_last),
  .o_status     (out_if.status)
);
